>>> hw/rtl/abpre_pkg.sv
// Shared types, constants and code builders for the byte pair rank encoder.
// No dependencies; used by every module of the block.
package abpre_pkg;

  localparam int unsigned LIST_ENTRIES_DEF = 4367;
  localparam int unsigned COUNT_BITS_DEF   = 16;
  localparam int unsigned PAIR_W           = 16;
  localparam int unsigned CODE_W           = 15;
  localparam int unsigned LEN_W            = 4;
  localparam logic [15:0] TERM_CODE        = 16'd4367;
  localparam logic [15:0] SHORT_LIMIT      = 16'd16;
  localparam logic [15:0] MID_LIMIT        = 16'd272;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_BUMP,
    OP_CLEAR
  } rank_op_e;

  typedef struct packed {
    logic              valid;
    rank_op_e          op;
    logic [PAIR_W-1:0] pair;
  } rank_cmd_t;

  typedef struct packed {
    logic        done;
    logic        hit;
    logic [15:0] rank;
  } rank_resp_t;

  typedef struct packed {
    logic [CODE_W-1:0] val;
    logic [LEN_W-1:0]  len;
  } code_t;

  typedef struct packed {
    logic  valid;
    code_t code;
    logic  term;
  } pack_push_t;

  function automatic code_t lit_code(input logic [7:0] b);
    code_t c;
    c.val = {7'd0, b};
    c.len = 4'd9;
    return c;
  endfunction

  function automatic code_t rank_code(input logic [15:0] r);
    code_t       c;
    logic [15:0] d;
    if (r < SHORT_LIMIT) begin
      c.val = {9'd0, 2'b10, r[3:0]};
      c.len = 4'd6;
    end else if (r < MID_LIMIT) begin
      d     = r - SHORT_LIMIT;
      c.val = {4'd0, 3'b110, d[7:0]};
      c.len = 4'd11;
    end else begin
      d     = r - MID_LIMIT;
      c.val = {3'b111, d[11:0]};
      c.len = 4'd15;
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/abpre_packer.sv
// Bit packer: collects variable length codes, sends bytes MSB first.
// Depends on abpre_pkg; drives the output register of the stream.
module abpre_packer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  abpre_pkg::pack_push_t push_i,
  output logic                 push_rdy_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic [7:0]           m_data_o,
  output logic                 m_last_o
);
  import abpre_pkg::*;

  localparam int unsigned ACC_W = 22;

  logic [ACC_W-1:0] acc_q;
  logic [4:0]       cnt_q;
  logic             term_q;
  logic             valid_q;
  logic [7:0]       data_q;
  logic             last_q;
  logic             slot_free;
  logic [ACC_W-1:0] shifted;

  assign push_rdy_o = (cnt_q < 5'd8) && !term_q;
  assign slot_free  = !valid_q || m_ready_i;
  assign shifted    = acc_q >> (cnt_q - 5'd8);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      cnt_q   <= '0;
      term_q  <= 1'b0;
      valid_q <= 1'b0;
      data_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      if (push_i.valid && push_rdy_o) begin
        acc_q  <= (acc_q << push_i.code.len) | ACC_W'(push_i.code.val);
        cnt_q  <= cnt_q + 5'(push_i.code.len);
        term_q <= push_i.term;
        if (m_ready_i) begin
          valid_q <= 1'b0;
        end
      end else if (slot_free && cnt_q >= 5'd8) begin
        valid_q <= 1'b1;
        data_q  <= shifted[7:0];
        last_q  <= term_q && (cnt_q == 5'd8);
        cnt_q   <= cnt_q - 5'd8;
        if (cnt_q == 5'd8) begin
          term_q <= 1'b0;
        end
      end else if (slot_free && term_q) begin
        valid_q <= 1'b1;
        data_q  <= 8'(acc_q[7:0] << (4'd8 - cnt_q[3:0]));
        last_q  <= 1'b1;
        cnt_q   <= '0;
        term_q  <= 1'b0;
      end else if (m_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;
  assign m_last_o  = last_q;

endmodule

>>> hw/rtl/abpre_rank_unit.sv
// Pair count table and rank list with the insertion sequencer that bumps pairs.
// Depends on abpre_pkg; holds the pair slot memory and the rank memory.
module abpre_rank_unit #(
  parameter int unsigned LIST_ENTRIES = abpre_pkg::LIST_ENTRIES_DEF,
  parameter int unsigned COUNT_BITS   = abpre_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  abpre_pkg::rank_cmd_t  cmd_i,
  output abpre_pkg::rank_resp_t resp_o
);
  import abpre_pkg::*;

  localparam int unsigned IDX_W  = $clog2(LIST_ENTRIES);
  localparam int unsigned FILL_W = $clog2(LIST_ENTRIES + 1);
  localparam int unsigned VAL_W  = (COUNT_BITS > IDX_W) ? COUNT_BITS : IDX_W;
  localparam int unsigned SLOT_W = VAL_W + 1;
  localparam int unsigned ENT_W  = COUNT_BITS + PAIR_W;
  localparam int unsigned SLOTS  = 1 << PAIR_W;
  localparam logic [IDX_W-1:0]  LAST   = IDX_W'(LIST_ENTRIES - 1);
  localparam logic [FILL_W-1:0] FULL   = FILL_W'(LIST_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WAIT,
    S_SLOT,
    S_RANKRD,
    S_EVICT,
    S_SETTLE,
    S_CMP,
    S_CLEAR
  } state_e;

  logic [SLOT_W-1:0] slot_mem [SLOTS];
  logic [ENT_W-1:0]  rank_mem [LIST_ENTRIES];

  state_e               state_q, state_d;
  rank_op_e             op_q, op_d;
  logic [PAIR_W-1:0]    pair_q, pair_d;
  logic [IDX_W-1:0]     pos_q, pos_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [PAIR_W-1:0]    clr_q, clr_d;
  rank_resp_t           resp_q, resp_d;

  logic [SLOT_W-1:0]    slot_rd_q;
  logic [ENT_W-1:0]     rank_rd_q;
  logic                 slot_we;
  logic [PAIR_W-1:0]    slot_wa;
  logic [SLOT_W-1:0]    slot_wd;
  logic                 rank_we;
  logic [IDX_W-1:0]     rank_wa;
  logic [ENT_W-1:0]     rank_wd;
  logic [IDX_W-1:0]     rank_ra;

  logic                  s_ranked;
  logic [COUNT_BITS-1:0] s_cnt;
  logic [IDX_W-1:0]      s_pos;
  logic [COUNT_BITS-1:0] e_cnt;
  logic [PAIR_W-1:0]     e_pair;
  logic [COUNT_BITS-1:0] f_cnt;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + COUNT_BITS'(1);
  endfunction

  assign s_ranked = slot_rd_q[VAL_W];
  assign s_cnt    = slot_rd_q[COUNT_BITS-1:0];
  assign s_pos    = slot_rd_q[IDX_W-1:0];
  assign e_cnt    = rank_rd_q[ENT_W-1:PAIR_W];
  assign e_pair   = rank_rd_q[PAIR_W-1:0];
  assign f_cnt    = sat_inc(s_cnt);

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd_q <= slot_mem[pair_q];
  end

  always_ff @(posedge clk_i) begin
    if (rank_we) begin
      rank_mem[rank_wa] <= rank_wd;
    end
    rank_rd_q <= rank_mem[rank_ra];
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    pair_d  = pair_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    fill_d  = fill_q;
    clr_d   = clr_q;
    resp_d  = '0;
    resp_d.hit  = resp_q.hit;
    resp_d.rank = resp_q.rank;
    slot_we = 1'b0;
    slot_wa = pair_q;
    slot_wd = '0;
    rank_we = 1'b0;
    rank_wa = pos_q;
    rank_wd = {cnt_q, pair_q};
    rank_ra = pos_q - IDX_W'(1);
    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          op_d   = cmd_i.op;
          pair_d = cmd_i.pair;
          clr_d  = '0;
          state_d = (cmd_i.op == OP_CLEAR) ? S_CLEAR : S_WAIT;
        end
      end
      S_WAIT: begin
        state_d = S_SLOT;
      end
      S_SLOT: begin
        if (op_q == OP_LOOKUP) begin
          resp_d.done = 1'b1;
          resp_d.hit  = s_ranked;
          resp_d.rank = 16'(s_pos);
          state_d = S_IDLE;
        end else if (s_ranked) begin
          pos_d   = s_pos;
          rank_ra = s_pos;
          state_d = S_RANKRD;
        end else begin
          slot_we = 1'b1;
          slot_wd = {1'b0, VAL_W'(f_cnt)};
          cnt_d   = f_cnt;
          if (fill_q < FULL) begin
            pos_d   = IDX_W'(fill_q);
            fill_d  = fill_q + FILL_W'(1);
            state_d = S_SETTLE;
          end else begin
            rank_ra = LAST;
            state_d = S_EVICT;
          end
        end
      end
      S_RANKRD: begin
        cnt_d   = sat_inc(e_cnt);
        state_d = S_SETTLE;
      end
      S_EVICT: begin
        if (cnt_q < e_cnt) begin
          resp_d.done = 1'b1;
          state_d = S_IDLE;
        end else begin
          slot_we = 1'b1;
          slot_wa = e_pair;
          slot_wd = {1'b0, VAL_W'(e_cnt)};
          pos_d   = LAST;
          state_d = S_SETTLE;
        end
      end
      S_SETTLE: begin
        if (pos_q != '0) begin
          state_d = S_CMP;
        end else begin
          rank_we = 1'b1;
          slot_we = 1'b1;
          slot_wd = {1'b1, VAL_W'(pos_q)};
          resp_d.done = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CMP: begin
        rank_we = 1'b1;
        slot_we = 1'b1;
        slot_wd = {1'b1, VAL_W'(pos_q)};
        if (cnt_q >= e_cnt) begin
          rank_wd = rank_rd_q;
          slot_wa = e_pair;
          pos_d   = pos_q - IDX_W'(1);
          state_d = S_SETTLE;
        end else begin
          resp_d.done = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        slot_we = 1'b1;
        slot_wa = clr_q;
        clr_d   = clr_q + PAIR_W'(1);
        if (&clr_q) begin
          fill_d  = '0;
          resp_d.done = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      op_q    <= OP_CLEAR;
      pair_q  <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
      fill_q  <= '0;
      clr_q   <= '0;
      resp_q  <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      pair_q  <= pair_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      fill_q  <= fill_d;
      clr_q   <= clr_d;
      resp_q  <= resp_d;
    end
  end

  assign resp_o = resp_q;

endmodule

>>> hw/rtl/adaptive_byte_pair_rank_encoder.sv
// Top level of the adaptive byte pair rank encoder: stream ports and byte sequencer.
// Depends on abpre_pkg, abpre_rank_unit and abpre_packer.
//
// One byte is taken per input transaction; tready stays low while the byte is
// worked on. A later byte needs a pair lookup and one pair bump when the pair
// ahead is not ranked, and a pair lookup and two pair bumps when it is. A bumped
// pair is moved up the rank list one entry at a time, since the rank memory has
// a single read port. Output bytes leave through a register and back pressure
// only delays the sequencer where code bits must be pushed. After reset and
// after the last byte of each stream the pair table is cleared one entry per
// cycle, with tready low.
module adaptive_byte_pair_rank_encoder #(
  parameter int unsigned LIST_ENTRIES = abpre_pkg::LIST_ENTRIES_DEF,
  parameter int unsigned COUNT_BITS   = abpre_pkg::COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] byte_in
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast
);
  import abpre_pkg::*;

  typedef enum logic [3:0] {
    T_CLR_REQ,
    T_CLR_WAIT,
    T_IDLE,
    T_LIT0,
    T_LK_REQ,
    T_LK_WAIT,
    T_B1_REQ,
    T_B1_WAIT,
    T_B2_REQ,
    T_B2_WAIT,
    T_CODE,
    T_TRAIL,
    T_TERM,
    T_DRAIN
  } state_e;

  typedef enum logic [1:0] {
    PH_NONE,
    PH_ONE,
    PH_TWO
  } phase_e;

  state_e      state_q;
  phase_e      phase_q;
  logic [7:0]  prev_q;
  logic [7:0]  held_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic        hit_q;
  logic [15:0] rank_q;

  rank_cmd_t   cmd;
  rank_resp_t  resp;
  pack_push_t  push;
  logic        push_rdy;

  abpre_rank_unit #(
    .LIST_ENTRIES(LIST_ENTRIES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_rank (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .resp_o(resp)
  );

  abpre_packer u_pack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_rdy_o(push_rdy),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

  assign s_axis_tready = (state_q == T_IDLE);

  always_comb begin
    cmd = '0;
    cmd.op = OP_LOOKUP;
    case (state_q)
      T_CLR_REQ: begin
        cmd.valid = 1'b1;
        cmd.op    = OP_CLEAR;
      end
      T_LK_REQ: begin
        cmd.valid = 1'b1;
        cmd.pair  = {held_q, byte_q};
      end
      T_B1_REQ: begin
        cmd.valid = 1'b1;
        cmd.op    = OP_BUMP;
        cmd.pair  = {held_q, byte_q};
      end
      T_B2_REQ: begin
        cmd.valid = 1'b1;
        cmd.op    = OP_BUMP;
        cmd.pair  = {prev_q, held_q};
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    push = '0;
    case (state_q)
      T_LIT0: begin
        push.valid = 1'b1;
        push.code  = lit_code(byte_q);
      end
      T_CODE: begin
        push.valid = 1'b1;
        push.code  = hit_q ? rank_code(rank_q) : lit_code(held_q);
      end
      T_TRAIL: begin
        push.valid = 1'b1;
        push.code  = lit_code(held_q);
      end
      T_TERM: begin
        push.valid = 1'b1;
        push.code  = rank_code(TERM_CODE);
        push.term  = 1'b1;
      end
      default: begin
        push = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_CLR_WAIT;
      phase_q <= PH_NONE;
      prev_q  <= '0;
      held_q  <= '0;
      byte_q  <= '0;
      last_q  <= 1'b0;
      hit_q   <= 1'b0;
      rank_q  <= '0;
    end else begin
      case (state_q)
        T_CLR_REQ: begin
          state_q <= T_CLR_WAIT;
        end
        T_CLR_WAIT: begin
          if (resp.done) begin
            state_q <= T_IDLE;
          end
        end
        T_IDLE: begin
          if (s_axis_tvalid) begin
            byte_q <= s_axis_tdata;
            last_q <= s_axis_tlast;
            case (phase_q)
              PH_NONE: begin
                prev_q  <= s_axis_tdata;
                phase_q <= PH_ONE;
                state_q <= T_LIT0;
              end
              PH_ONE: begin
                held_q  <= s_axis_tdata;
                phase_q <= PH_TWO;
                if (s_axis_tlast) begin
                  state_q <= T_TRAIL;
                end
              end
              default: begin
                state_q <= T_LK_REQ;
              end
            endcase
          end
        end
        T_LIT0: begin
          if (push_rdy) begin
            state_q <= last_q ? T_TERM : T_IDLE;
          end
        end
        T_LK_REQ: begin
          state_q <= T_LK_WAIT;
        end
        T_LK_WAIT: begin
          if (resp.done) begin
            hit_q   <= resp.hit;
            rank_q  <= resp.rank;
            state_q <= resp.hit ? T_B1_REQ : T_B2_REQ;
          end
        end
        T_B1_REQ: begin
          state_q <= T_B1_WAIT;
        end
        T_B1_WAIT: begin
          if (resp.done) begin
            state_q <= T_B2_REQ;
          end
        end
        T_B2_REQ: begin
          state_q <= T_B2_WAIT;
        end
        T_B2_WAIT: begin
          if (resp.done) begin
            state_q <= T_CODE;
          end
        end
        T_CODE: begin
          if (push_rdy) begin
            if (hit_q) begin
              prev_q  <= byte_q;
              phase_q <= PH_ONE;
            end else begin
              prev_q  <= held_q;
              held_q  <= byte_q;
              phase_q <= PH_TWO;
            end
            if (!last_q) begin
              state_q <= T_IDLE;
            end else begin
              state_q <= hit_q ? T_TERM : T_TRAIL;
            end
          end
        end
        T_TRAIL: begin
          if (push_rdy) begin
            state_q <= T_TERM;
          end
        end
        T_TERM: begin
          if (push_rdy) begin
            state_q <= T_DRAIN;
          end
        end
        T_DRAIN: begin
          if (push_rdy) begin
            phase_q <= PH_NONE;
            prev_q  <= '0;
            held_q  <= '0;
            state_q <= T_CLR_REQ;
          end
        end
        default: begin
          state_q <= T_IDLE;
        end
      endcase
    end
  end

endmodule
